@@ hdl/roch_pkg.sv @@
// roch_pkg: constants and types shared by the ray/box closest-hit core.
// No dependencies.
`default_nettype none
package roch_pkg;
  localparam int AXIS_W = 2;
  localparam logic [AXIS_W-1:0] LAST_AXIS = 2'd2;
  localparam logic [31:0] DIST_MAX = 32'h7FFF_FFFF;
  localparam logic [49:0] PARALLEL_EPS = 50'd268435;

  localparam logic [2:0] REG_ORG_X = 3'd0;
  localparam logic [2:0] REG_ORG_Y = 3'd1;
  localparam logic [2:0] REG_ORG_Z = 3'd2;
  localparam logic [2:0] REG_DIR_X = 3'd3;
  localparam logic [2:0] REG_DIR_Y = 3'd4;
  localparam logic [2:0] REG_DIR_Z = 3'd5;

  typedef struct packed {
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] slab_min;
    logic signed [31:0] slab_max;
    logic [1:0]         axis_index;
    logic [9:0]         box_id;
    logic               last_box;
  } box_item_t;

  typedef struct packed {
    logic        box_hit;
    logic [30:0] box_distance;
    logic        best_valid;
    logic [9:0]  best_id;
    logic [30:0] best_distance;
    logic        pick_done;
  } hit_item_t;
endpackage
`default_nettype wire

@@ hdl/roch_if.sv @@
// roch_if: valid/ready channel carrying a payload of type T.
// The payload type is a parameter; no dependencies.
`default_nettype none
interface roch_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/ray_obb_closest_hit_core.sv @@
// Ray against oriented box closest-hit core: shared multiplier and serial divider.
// Depends on roch_pkg and roch_if.
//
// Usage: write the ray origin (Q16.16) and unit direction (Q1.14) through the
// config port (cfg_we, cfg_index, cfg_data) while idle. Boxes stream in on
// box_in, three items per box (axis_index 0..2). Axis 0 also carries the box
// position. The item with axis_index 2 produces one result on hit_out: this
// box's hit and entry distance and the running closest hit; pick_done marks
// the result of a box flagged last_box, after which the best is cleared.
// Items with axis_index 3 are dropped.
// Datapath: one 33x16 multiplier forms three products for the position dot and
// three for the direction dot, one per cycle; one shared restoring divider
// then computes each slab distance. After an item is accepted box_in.ready
// stays low through the products and both divisions (axis 0 first adds three
// subtracts); a nearly parallel axis skips the divisions and an axis of an
// already missed box goes straight to the update; the result state on axis 2
// follows the update. One item at a time.
// Reset (rst, synchronous) clears the interval, best hit and ray registers.
// A stalled receiver holds the result in the output register; input keeps
// flowing and the core only waits once the next result is due.
`default_nettype none
module ray_obb_closest_hit_core (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  roch_if.sink       box_in,
  roch_if.source     hit_out
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_REL = 7'b0000010, S_MUL = 7'b0000100,
    S_DEC = 7'b0001000, S_DIV = 7'b0010000, S_UPD = 7'b0100000,
    S_OUT = 7'b1000000
  } state_t;

  state_t state;
  logic signed [31:0] org [3];
  logic signed [15:0] dir [3];
  roch_pkg::box_item_t it;
  logic signed [32:0] rel_pos [3];
  logic signed [31:0] near_t, far_t;
  logic box_missed;
  logic signed [31:0] best_dist;
  logic [9:0] best_box;
  logic best_found;
  logic [2:0] step;
  logic [1:0] rsel;
  logic signed [49:0] e_acc, f_acc;
  logic signed [31:0] t1;
  logic second;
  // divider
  logic [49:0] dq, dr;
  logic [35:0] dd;
  logic [5:0] dcnt;
  logic dneg;
  roch_pkg::hit_item_t res;
  logic res_valid;
  logic out_go;

  // shared multiplier operands
  logic signed [32:0] ma;
  logic signed [15:0] mb;
  logic signed [48:0] mp;
  logic signed [15:0] axv;
  always_comb begin
    unique case (step[1:0])
      2'd0: axv = it.axis_x;
      2'd1: axv = it.axis_y;
      default: axv = it.axis_z;
    endcase
    if (step[2]) begin
      ma = 33'(dir[step[1:0]]);
    end else begin
      ma = rel_pos[step[1:0]];
    end
    mb = axv;
    mp = ma * mb;
  end

  logic signed [49:0] smin_s, smax_s, num, f_abs;
  logic signed [50:0] num_w;
  logic [49:0] nmag;
  logic [63:0] nsh;
  logic [50:0] dr_try;
  logic [31:0] q_sat;
  always_comb begin
    smin_s = 50'(it.slab_min) <<< 14;
    smax_s = 50'(it.slab_max) <<< 14;
    num    = second ? (e_acc + smax_s) : (e_acc + smin_s);
    f_abs  = f_acc[49] ? -f_acc : f_acc;
    num_w  = 51'(num);
    nmag   = num[49] ? 50'(-num_w) : 50'(num);
    nsh    = {nmag, 14'd0};
    dr_try = {dr, dq[49]} - {15'd0, dd};
    if (dneg) begin
      q_sat = (dq > 50'd2147483648) ? 32'h8000_0000 : 32'(-dq);
    end else begin
      q_sat = (dq > 50'(roch_pkg::DIST_MAX)) ? roch_pkg::DIST_MAX : dq[31:0];
    end
  end

  logic signed [31:0] tl, th, far_n, near_n;
  always_comb begin
    tl = (t1 > $signed(q_sat)) ? $signed(q_sat) : t1;
    th = (t1 > $signed(q_sat)) ? t1 : $signed(q_sat);
    far_n  = (th < far_t) ? th : far_t;
    near_n = (tl > near_t) ? tl : near_t;
  end

  // result register is free, or being emptied this cycle
  assign out_go        = (state == S_OUT) && (!res_valid || hit_out.ready);
  assign box_in.ready  = (state == S_IDLE);
  assign hit_out.valid = res_valid;
  assign hit_out.data  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
      org[0] <= '0; org[1] <= '0; org[2] <= '0;
      dir[0] <= '0; dir[1] <= '0; dir[2] <= '0;
      rel_pos[0] <= '0; rel_pos[1] <= '0; rel_pos[2] <= '0;
      near_t <= 32'sd0;
      far_t <= roch_pkg::DIST_MAX;
      box_missed <= 1'b0;
      best_dist <= roch_pkg::DIST_MAX;
      best_box <= '0;
      best_found <= 1'b0;
      step <= '0;
      second <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          roch_pkg::REG_ORG_X: org[0] <= cfg_data;
          roch_pkg::REG_ORG_Y: org[1] <= cfg_data;
          roch_pkg::REG_ORG_Z: org[2] <= cfg_data;
          roch_pkg::REG_DIR_X: dir[0] <= cfg_data[15:0];
          roch_pkg::REG_DIR_Y: dir[1] <= cfg_data[15:0];
          roch_pkg::REG_DIR_Z: dir[2] <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (out_go) res_valid <= 1'b1;
      else if (hit_out.valid && hit_out.ready) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (box_in.valid && box_in.ready) begin
            it <= box_in.data;
            if (box_in.data.axis_index == 2'd3) begin
              state <= S_IDLE;
            end else if (box_in.data.axis_index == 2'd0) begin
              near_t <= 32'sd0;
              far_t <= roch_pkg::DIST_MAX;
              box_missed <= 1'b0;
              rsel <= 2'd0;
              state <= S_REL;
            end else begin
              step <= 3'd0;
              e_acc <= '0;
              f_acc <= '0;
              state <= box_missed ? S_UPD : S_MUL;
            end
          end
        end
        S_REL: begin
          // one 33-bit subtract per cycle
          unique case (rsel)
            2'd0: rel_pos[0] <= 33'(it.pos_x) - 33'(org[0]);
            2'd1: rel_pos[1] <= 33'(it.pos_y) - 33'(org[1]);
            default: rel_pos[2] <= 33'(it.pos_z) - 33'(org[2]);
          endcase
          rsel <= rsel + 2'd1;
          if (rsel == 2'd2) begin
            step <= 3'd0;
            e_acc <= '0;
            f_acc <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (step[2]) f_acc <= f_acc + 50'(mp);
          else e_acc <= e_acc + 50'(mp);
          if (step == 3'd6) begin
            second <= 1'b0;
            state <= S_DEC;
          end else if (step == 3'd2) step <= 3'd4;
          else step <= step + 3'd1;
        end
        S_DEC: begin
          if (f_abs > roch_pkg::PARALLEL_EPS) begin
            dq <= nsh[49:0];
            dr <= 50'(nsh[63:50]);
            dd <= f_abs[35:0];
            dneg <= num[49] ^ f_acc[49];
            dcnt <= '0;
            state <= S_DIV;
          end else begin
            if ((smin_s - e_acc > 0) || (smax_s - e_acc < 0)) box_missed <= 1'b1;
            state <= S_UPD;
          end
        end
        S_DIV: begin
          if (dcnt == 6'd50) begin
            // quotient complete in dq
            if (!second) begin
              t1 <= $signed(q_sat);
              second <= 1'b1;
              state <= S_DEC;
            end else begin
              far_t <= far_n;
              near_t <= near_n;
              if (far_n < near_n) box_missed <= 1'b1;
              state <= S_UPD;
            end
          end else begin
            if (!dr_try[50]) begin
              dr <= dr_try[49:0];
              dq <= {dq[48:0], 1'b1};
            end else begin
              dr <= {dr[48:0], dq[49]};
              dq <= {dq[48:0], 1'b0};
            end
            dcnt <= dcnt + 6'd1;
          end
        end
        S_UPD: state <= (it.axis_index == roch_pkg::LAST_AXIS) ? S_OUT : S_IDLE;
        S_OUT: begin
          if (out_go) begin
            res.box_hit <= !box_missed;
            res.box_distance <= box_missed ? 31'd0 : near_t[30:0];
            res.pick_done <= it.last_box;
            if (!box_missed && near_t < best_dist) begin
              res.best_valid <= 1'b1;
              res.best_id <= it.box_id;
              res.best_distance <= near_t[30:0];
            end else begin
              res.best_valid <= best_found;
              res.best_id <= best_box;
              res.best_distance <= best_dist[30:0];
            end
            if (it.last_box) begin
              best_dist <= roch_pkg::DIST_MAX;
              best_box <= '0;
              best_found <= 1'b0;
            end else if (!box_missed && near_t < best_dist) begin
              best_dist <= near_t;
              best_box <= it.box_id;
              best_found <= 1'b1;
            end
            near_t <= 32'sd0;
            far_t <= roch_pkg::DIST_MAX;
            box_missed <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state)) else $error("state not one-hot");
  a_best_sat: assert property (@(posedge clk) disable iff (rst)
    !best_found |-> best_dist == roch_pkg::DIST_MAX) else $error("best not clear");
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (hit_out.valid && !hit_out.ready) |=> $stable(res)) else $error("result moved");
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    (hit_out.valid && !hit_out.ready) |=> hit_out.valid) else $error("result dropped");
`endif
endmodule
`default_nettype wire
